// File: hw/rtl/lsbse_pkg.sv
package lsbse_pkg;

    localparam int PIXEL_INDEX_BITS_DEF = 24;
    localparam int MSG_LENGTH_BITS_DEF  = 16;

    localparam int PIXEL_COUNT_W = 25;
    localparam int MSG_LEN_W     = 16;
    localparam int CFG_DATA_W    = 25;
    localparam int CFG_INDEX_W   = 2;

    localparam logic [7:0] MARK_MASK  = 8'b1111_1000;
    localparam logic [7:0] MARK_VALUE = 8'b1010_0000;

    localparam logic MODE_EMBED   = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MODE        = 2'd0,
        CFG_PIXEL_COUNT = 2'd1,
        CFG_MSG_LENGTH  = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_MARKED    = 3'd1,
        ST_TOO_LONG  = 3'd2,
        ST_NO_MARKER = 3'd3,
        ST_NO_TERM   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CH_RED,
        CH_GREEN,
        CH_BLUE
    } chan_t;

    typedef struct packed {
        logic                     mode;
        logic [PIXEL_COUNT_W-1:0] pixel_count;
        logic [MSG_LEN_W-1:0]     message_length;
    } cfg_t;

    typedef struct packed {
        logic       first_pixel;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] msg_char;
    } pix_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] char_out;
        logic       char_valid;
        status_t    status;
        logic       image_last;
    } result_t;

endpackage

// File: hw/rtl/lsbse_cfg.sv
module lsbse_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lsbse_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lsbse_pkg::CFG_DATA_W-1:0]    cfg_data,
    output lsbse_pkg::cfg_t                     cfg
);
    import lsbse_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MODE:        cfg_next.mode           = cfg_data[0];
                CFG_PIXEL_COUNT: cfg_next.pixel_count    = cfg_data[PIXEL_COUNT_W-1:0];
                CFG_MSG_LENGTH:  cfg_next.message_length = cfg_data[MSG_LEN_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode           <= MODE_EMBED;
            cfg_reg.pixel_count    <= PIXEL_COUNT_W'(1);
            cfg_reg.message_length <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hw/rtl/lsbse_engine.sv
module lsbse_engine
#(
    parameter int PIXEL_INDEX_BITS = lsbse_pkg::PIXEL_INDEX_BITS_DEF,
    parameter int MSG_LENGTH_BITS  = lsbse_pkg::MSG_LENGTH_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  lsbse_pkg::cfg_t     cfg,
    input  lsbse_pkg::pix_t     pix,
    output lsbse_pkg::result_t  res
);
    import lsbse_pkg::*;

    localparam int PW  = PIXEL_INDEX_BITS;
    localparam int CW  = (PW + 1 > PIXEL_COUNT_W) ? PW + 1 : PIXEL_COUNT_W;
    localparam int XW  = (PW > MSG_LEN_W + 4) ? PW : MSG_LEN_W + 4;
    localparam int CDW = (MSG_LENGTH_BITS > MSG_LEN_W) ? MSG_LENGTH_BITS : MSG_LEN_W;
    localparam logic [CDW-1:0] CHARS_MAX = {CDW{1'b1}} >> (CDW - MSG_LENGTH_BITS);
    localparam logic [CW-1:0]  COUNT_LIM = CW'(1) << PW;

    logic [PW-1:0]  idx_reg,    idx_next;
    logic [2:0]     mod6_reg,   mod6_next;
    logic [2:0]     bp_reg,     bp_next;
    logic [7:0]     shift_reg,  shift_next;
    logic [CDW-1:0] cd_reg,     cd_next;
    status_t        status_reg, status_next;
    logic           fin_reg,    fin_next;
    logic           over_reg,   over_next;

    logic [PW-1:0]  s_idx;
    logic [2:0]     s_mod6;
    logic [2:0]     s_bp;
    logic [7:0]     s_shift;
    logic [CDW-1:0] s_cd;
    status_t        s_status;
    logic           s_fin;
    logic           s_over;

    logic [CW-1:0]  pc_ext;
    logic [CW-1:0]  last_full;
    logic [PW-1:0]  last_idx;
    logic [XW-1:0]  need_bits;
    logic           too_long;
    logic           marked;
    logic           is_last;
    logic           more_chars;
    chan_t          chan;
    logic           chan_lsb;
    logic [7:0]     shift_src;
    logic [7:0]     ext_shift;
    logic           emb_bit;

    // Last pixel index and capacity from the current configuration
    always_comb
    begin
        pc_ext = CW'(cfg.pixel_count);
        if (pc_ext == '0)
            last_full = '0;
        else if (pc_ext > COUNT_LIM)
            last_full = COUNT_LIM - CW'(1);
        else
            last_full = pc_ext - CW'(1);
        last_idx  = last_full[PW-1:0];
        need_bits = XW'({XW'(cfg.message_length) + XW'(1), 3'b000});
        too_long  = need_bits > XW'(last_idx);
    end

    always_comb
    begin
        // A first pixel restarts the job before anything else
        if (pix.first_pixel)
        begin
            s_idx    = '0;
            s_mod6   = '0;
            s_bp     = '0;
            s_shift  = '0;
            s_cd     = '0;
            s_status = ST_OK;
            s_fin    = 1'b0;
            s_over   = 1'b0;
        end
        else
        begin
            s_idx    = idx_reg;
            s_mod6   = mod6_reg;
            s_bp     = bp_reg;
            s_shift  = shift_reg;
            s_cd     = cd_reg;
            s_status = status_reg;
            s_fin    = fin_reg;
            s_over   = over_reg;
        end

        idx_next    = s_idx;
        mod6_next   = s_mod6;
        bp_next     = s_bp;
        shift_next  = s_shift;
        cd_next     = s_cd;
        status_next = s_status;
        fin_next    = s_fin;
        over_next   = s_over;

        res.red        = pix.red;
        res.green      = pix.green;
        res.blue       = pix.blue;
        res.char_out   = '0;
        res.char_valid = 1'b0;
        res.image_last = 1'b0;

        marked  = (pix.red & MARK_MASK) == MARK_VALUE;
        is_last = s_idx == last_idx;

        if (!s_mod6[0])
            chan = CH_GREEN;
        else if (s_mod6 == 3'd3)
            chan = CH_BLUE;
        else
            chan = CH_RED;

        case (chan)
            CH_GREEN: chan_lsb = pix.green[0];
            CH_BLUE:  chan_lsb = pix.blue[0];
            default:  chan_lsb = pix.red[0];
        endcase

        more_chars = s_cd < CDW'(cfg.message_length);
        shift_src  = (s_bp == '0) ? (more_chars ? pix.msg_char : 8'h00) : s_shift;
        emb_bit    = shift_src[7];
        ext_shift  = {s_shift[6:0], chan_lsb};

        if (!s_over)
        begin
            res.image_last = is_last;
            if (s_idx == '0)
            begin
                if (cfg.mode == MODE_EMBED)
                begin
                    if (marked)
                        status_next = ST_MARKED;
                    else if (too_long)
                        status_next = ST_TOO_LONG;
                    else
                    begin
                        status_next = ST_OK;
                        res.red     = (pix.red & ~MARK_MASK) | MARK_VALUE;
                    end
                end
                else
                begin
                    status_next = marked ? ST_OK : ST_NO_MARKER;
                end
            end
            else if (s_status == ST_OK && !s_fin)
            begin
                bp_next = s_bp + 3'd1;
                if (cfg.mode == MODE_EMBED)
                begin
                    shift_next = {shift_src[6:0], 1'b0};
                    case (chan)
                        CH_GREEN: res.green = {pix.green[7:1], emb_bit};
                        CH_BLUE:  res.blue  = {pix.blue[7:1], emb_bit};
                        default:  res.red   = {pix.red[7:1], emb_bit};
                    endcase
                    if (s_bp == 3'd7)
                    begin
                        if (more_chars)
                            cd_next = s_cd + CDW'(1);
                        else
                            fin_next = 1'b1;
                    end
                end
                else
                begin
                    shift_next = ext_shift;
                    if (s_bp == 3'd7)
                    begin
                        if (ext_shift == 8'h00)
                            fin_next = 1'b1;
                        else
                        begin
                            res.char_out   = ext_shift;
                            res.char_valid = 1'b1;
                            if (s_cd < CHARS_MAX)
                                cd_next = s_cd + CDW'(1);
                        end
                    end
                end
            end

            if (is_last)
            begin
                if (cfg.mode == MODE_EXTRACT && status_next == ST_OK && !fin_next)
                    status_next = ST_NO_TERM;
                over_next = 1'b1;
            end
            else
            begin
                idx_next  = s_idx + PW'(1);
                mod6_next = (s_mod6 >= 3'd5) ? 3'd0 : s_mod6 + 3'd1;
            end
        end

        res.status = status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            mod6_reg   <= '0;
            bp_reg     <= '0;
            shift_reg  <= '0;
            cd_reg     <= '0;
            status_reg <= ST_OK;
            fin_reg    <= 1'b0;
            over_reg   <= 1'b0;
        end
        else if (take)
        begin
            idx_reg    <= idx_next;
            mod6_reg   <= mod6_next;
            bp_reg     <= bp_next;
            shift_reg  <= shift_next;
            cd_reg     <= cd_next;
            status_reg <= status_next;
            fin_reg    <= fin_next;
            over_reg   <= over_next;
        end
    end

endmodule

// File: hw/rtl/lsb_stego_embed_extract_core.sv
// An accepted pixel word's result is registered and shows in the next cycle; one pixel
// per cycle is taken unless a stalled word waits. The per-image counters update in
// the accept cycle, and the result register takes a new word whenever it is empty
// or being drained. Reset (rst_n low, asynchronous): result register empty, job state
// cleared to pixel 0 with status ok, mode embed, pixel_count 1, message_length 0.
module lsb_stego_embed_extract_core
#(
    parameter int PIXEL_INDEX_BITS = lsbse_pkg::PIXEL_INDEX_BITS_DEF,
    parameter int MSG_LENGTH_BITS  = lsbse_pkg::MSG_LENGTH_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lsbse_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lsbse_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          red,
    input  logic [7:0]                          green,
    input  logic [7:0]                          blue,
    input  logic                                first_pixel,
    input  logic [7:0]                          msg_char,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [7:0]                          red_out,
    output logic [7:0]                          green_out,
    output logic [7:0]                          blue_out,
    output logic [7:0]                          char_out,
    output logic                                char_valid,
    output logic [2:0]                          status,
    output logic                                image_last
);
    import lsbse_pkg::*;

    cfg_t    cfg;
    pix_t    pix;
    result_t res;
    result_t res_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    take;

    assign in_stall = out_valid_reg & out_stall;
    assign take     = in_valid & ~in_stall;

    assign pix.first_pixel = first_pixel;
    assign pix.red         = red;
    assign pix.green       = green;
    assign pix.blue        = blue;
    assign pix.msg_char    = msg_char;

    lsbse_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lsbse_engine
    #(
        .PIXEL_INDEX_BITS (PIXEL_INDEX_BITS),
        .MSG_LENGTH_BITS  (MSG_LENGTH_BITS)
    )
    u_engine
    (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .cfg   (cfg),
        .pix   (pix),
        .res   (res)
    );

    // Hold the word while the sink stalls, refill on every accepted pixel
    assign out_valid_next = take | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            res_reg <= res;
    end

    assign out_valid  = out_valid_reg;
    assign red_out    = res_reg.red;
    assign green_out  = res_reg.green;
    assign blue_out   = res_reg.blue;
    assign char_out   = res_reg.char_out;
    assign char_valid = res_reg.char_valid;
    assign status     = res_reg.status;
    assign image_last = res_reg.image_last;

endmodule

// File: hw/rtl/lsbse_checker.sv
module lsbse_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] red_out,
    input logic [7:0] green_out,
    input logic [7:0] blue_out,
    input logic [7:0] char_out,
    input logic       char_valid,
    input logic [2:0] status,
    input logic       image_last
);

    // A stalled result word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(red_out) && $stable(green_out)
            && $stable(blue_out) && $stable(char_out) && $stable(status)
            && $stable(image_last))
        else $error("result word changed while stalled");

    // Back pressure only when a word is waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with room in the result register");

    // An accepted pixel always shows up in the next cycle
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted pixel produced no result word");

    // Characters are never zero, and zero when absent
    a_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (char_valid ? char_out != 8'h00 : char_out == 8'h00))
        else $error("extracted character inconsistent with char_valid");

endmodule

bind lsb_stego_embed_extract_core lsbse_checker u_lsbse_checker (.*);
